@@ hdl/assert_macros.svh @@
// Assertion macros shared by the key edge tracker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KET_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Check that a condition never holds on a rising clock edge outside reset.
`define KET_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition: %m");

`endif

@@ hdl/ket_pkg.sv @@
// Shared types and constants for the key edge tracker.
// No dependencies; imported by every module of the block.
package ket_pkg;

  localparam int CODE_W        = 8;
  localparam int LIMIT_W       = 16;
  localparam int STAMP_W       = 32;
  localparam int EVENT_W       = 2;
  localparam int KEY_COUNT_DEF = 256;
  localparam int TIME_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [EVENT_W-1:0] {
    EV_UP      = 2'd0,
    EV_DOWN    = 2'd1,
    EV_PRESS   = 2'd2,
    EV_RELEASE = 2'd3
  } key_event_e;

  typedef struct packed {
    logic               eof;
    logic [CODE_W-1:0]  key;
    logic               level;
    logic [LIMIT_W-1:0] limit;
    logic [STAMP_W-1:0] now;
  } cmd_t;

endpackage

@@ hdl/key_edge_tracker_with_tap_limit.sv @@
// Key edge tracker with tap limit: top level.
// Depends on ket_pkg, ket_front, ket_queue and ket_back.
//
// Input channel: drive the item on the field ports and raise push_i; the item
// transfers at a rising edge with push_i high and full_o low. mode_i high marks
// end of frame and clears all latched results; it produces no result. Queries
// for a key code at or beyond KEY_COUNT are dropped without a result.
// Result channel: while empty_o is low key_event_o holds the oldest result;
// it transfers at a rising edge with pop_i high and empty_o low.
// A query's result passes through the command queue, the table read registers
// and the result register before it shows on the ports. The back end takes one
// query at a time, a table read state followed by an update state, and takes no
// new item until the update is done; an end of frame needs only the read state.
// A two-entry command queue lets the input keep transferring while the back end works.
// When the result is not popped the back end holds its finished item, the
// queue fills and full_o rises; nothing is lost.
// Reset clears the seen, level and latch bits of every key and empties the
// queue and the result register; no clearing pass is needed.
module key_edge_tracker_with_tap_limit #(
  parameter int KEY_COUNT = ket_pkg::KEY_COUNT_DEF,
  parameter int TIME_BITS = ket_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        mode_i,
  input  logic [ket_pkg::CODE_W-1:0]  key_code_i,
  input  logic                        key_down_i,
  input  logic [ket_pkg::LIMIT_W-1:0] release_limit_ms_i,
  input  logic [ket_pkg::STAMP_W-1:0] now_ms_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [ket_pkg::EVENT_W-1:0] key_event_o
);
  import ket_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_cmd_in, q_cmd_out;

  ket_front #(
    .KEY_COUNT(KEY_COUNT)
  ) u_front (
    .push_i             (push_i),
    .mode_i             (mode_i),
    .key_code_i         (key_code_i),
    .key_down_i         (key_down_i),
    .release_limit_ms_i (release_limit_ms_i),
    .now_ms_i           (now_ms_i),
    .full_o             (full_o),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_cmd_o            (q_cmd_in)
  );

  ket_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd_out)
  );

  ket_back #(
    .KEY_COUNT(KEY_COUNT),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .key_event_o (key_event_o)
  );

endmodule

@@ hdl/ket_front.sv @@
// Front end: accepts input items, drops out-of-range queries, builds commands.
// Depends on ket_pkg.
module ket_front #(
  parameter int KEY_COUNT = ket_pkg::KEY_COUNT_DEF
) (
  input  logic                        push_i,
  input  logic                        mode_i,
  input  logic [ket_pkg::CODE_W-1:0]  key_code_i,
  input  logic                        key_down_i,
  input  logic [ket_pkg::LIMIT_W-1:0] release_limit_ms_i,
  input  logic [ket_pkg::STAMP_W-1:0] now_ms_i,
  output logic                        full_o,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ket_pkg::cmd_t               q_cmd_o
);
  import ket_pkg::*;

  logic [31:0] code_wide;
  logic        in_range;
  logic        accepted;

  assign code_wide = 32'(key_code_i);
  assign in_range  = code_wide < 32'(KEY_COUNT);
  assign accepted  = push_i && !q_full_i;

  assign full_o   = q_full_i;
  // Drop queries for keys beyond the table; end of frame goes through for any key code.
  assign q_push_o = accepted && (mode_i || in_range);

  assign q_cmd_o.eof   = mode_i;
  assign q_cmd_o.key   = key_code_i;
  assign q_cmd_o.level = key_down_i;
  assign q_cmd_o.limit = release_limit_ms_i;
  assign q_cmd_o.now   = now_ms_i;

endmodule

@@ hdl/ket_queue.sv @@
// Short command queue between the front and back ends.
// Depends on ket_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ket_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ket_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ket_pkg::cmd_t cmd_o
);
  import ket_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `KET_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > QCNT_W'(QUEUE_DEPTH))
  `KET_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

@@ hdl/ket_back.sv @@
// Back end: per-key table update, edge classification, release limit, result register.
// Depends on ket_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ket_back #(
  parameter int KEY_COUNT = ket_pkg::KEY_COUNT_DEF,
  parameter int TIME_BITS = ket_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  ket_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [ket_pkg::EVENT_W-1:0] key_event_o
);
  import ket_pkg::*;

  localparam int IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CEXT_W = (IDX_W > CODE_W) ? IDX_W : CODE_W;
  localparam int TEXT_W = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_q, state_d;
  cmd_t                 cmd_q;
  logic [TIME_BITS-1:0] stamp_mem [KEY_COUNT];
  logic [EVENT_W-1:0]   latch_mem [KEY_COUNT];
  logic [TIME_BITS-1:0] stamp_rd_q;
  logic [EVENT_W-1:0]   latch_rd_q;
  logic [KEY_COUNT-1:0] seen_q, level_q, lvalid_q;
  logic                 res_valid_q;
  logic [EVENT_W-1:0]   res_event_q;

  logic [CEXT_W-1:0]    rd_code_ext, wk_code_ext;
  logic [IDX_W-1:0]     rd_idx, wk_idx;
  logic [TEXT_W-1:0]    now_ext;
  logic [TIME_BITS-1:0] now_t, limit_t, stamp_eff, elapsed;
  logic                 idle_take, frame_end, slot_free, exec_fire;
  logic                 lv, seen, past, lvl, first, limit_on;
  logic                 stamp_we, latch_we;
  key_event_e           ev_raw, ev_out;

  assign rd_code_ext = CEXT_W'(q_cmd_i.key);
  assign rd_idx      = rd_code_ext[IDX_W-1:0];
  assign wk_code_ext = CEXT_W'(cmd_q.key);
  assign wk_idx      = wk_code_ext[IDX_W-1:0];

  assign idle_take = (state_q == ST_IDLE) && !q_empty_i;
  assign frame_end = idle_take && q_cmd_i.eof;
  assign q_pop_o   = idle_take;
  assign slot_free = !res_valid_q || pop_i;
  assign exec_fire = (state_q == ST_EXEC) && slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (idle_take && !q_cmd_i.eof) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign now_ext = TEXT_W'(cmd_q.now);
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign limit_t = TIME_BITS'(cmd_q.limit);

  assign lv       = lvalid_q[wk_idx];
  assign seen     = seen_q[wk_idx];
  assign past     = seen && level_q[wk_idx];
  assign lvl      = cmd_q.level;
  assign first    = !lv && !seen;
  assign limit_on = cmd_q.limit != '0;

  always_comb begin
    if (lv) begin
      ev_raw = key_event_e'(latch_rd_q);
    end else if (past == lvl) begin
      ev_raw = lvl ? EV_DOWN : EV_UP;
    end else begin
      ev_raw = lvl ? EV_PRESS : EV_RELEASE;
    end
  end

  assign stamp_eff = first ? now_t : stamp_rd_q;
  assign elapsed   = now_t - stamp_eff;
  assign ev_out    = (limit_on && (ev_raw == EV_RELEASE) && (elapsed > limit_t)) ?
                     EV_UP : ev_raw;
  assign stamp_we  = exec_fire && (first || (limit_on && (ev_raw == EV_PRESS)));
  assign latch_we  = exec_fire && !lv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      level_q     <= '0;
      lvalid_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (frame_end) begin
        lvalid_q <= '0;
      end else if (latch_we) begin
        lvalid_q[wk_idx] <= 1'b1;
        seen_q[wk_idx]   <= 1'b1;
        level_q[wk_idx]  <= lvl;
      end
      if (exec_fire) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (idle_take) begin
      cmd_q      <= q_cmd_i;
      stamp_rd_q <= stamp_mem[rd_idx];
      latch_rd_q <= latch_mem[rd_idx];
    end
    if (stamp_we) begin
      stamp_mem[wk_idx] <= now_t;
    end
    if (latch_we) begin
      latch_mem[wk_idx] <= ev_raw;
    end
    if (exec_fire) begin
      res_event_q <= ev_out;
    end
  end

  assign empty_o     = !res_valid_q;
  assign key_event_o = res_event_q;

  `KET_NEVER(a_latch_unseen, clk_i, rst_ni, (lvalid_q & ~seen_q) != '0)
  `KET_ASSERT(a_frame_clear, clk_i, rst_ni, frame_end |=> lvalid_q == '0)
  `KET_ASSERT(a_result_held, clk_i, rst_ni, res_valid_q && !pop_i |=> res_valid_q && $stable(res_event_q))
  `KET_NEVER(a_exec_no_take, clk_i, rst_ni, (state_q == ST_EXEC) && q_pop_o)

endmodule

@@ test/tb.sv @@
// Testbench for key_edge_tracker_with_tap_limit: directed table, then random frames.
// Depends on ket_pkg and the RTL of the block; results are checked against a local
// per-key predictor.
`timescale 1ns / 100ps

module tb;
  import ket_pkg::*;

  localparam int N_RANDOM   = 1400;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 20;

  typedef struct {
    logic               eof;
    logic [CODE_W-1:0]  key;
    logic               level;
    logic [LIMIT_W-1:0] limit;
    logic [STAMP_W-1:0] now;
    bit                 typed;
    key_event_e         want;
  } key_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push_i;
  logic               full_o;
  logic               mode_i;
  logic [CODE_W-1:0]  key_code_i;
  logic               key_down_i;
  logic [LIMIT_W-1:0] release_limit_ms_i;
  logic [STAMP_W-1:0] now_ms_i;
  logic               empty_o;
  logic               pop_i;
  logic [EVENT_W-1:0] key_event_o;

  key_edge_tracker_with_tap_limit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push_i),
    .full_o             (full_o),
    .mode_i             (mode_i),
    .key_code_i         (key_code_i),
    .key_down_i         (key_down_i),
    .release_limit_ms_i (release_limit_ms_i),
    .now_ms_i           (now_ms_i),
    .empty_o            (empty_o),
    .pop_i              (pop_i),
    .key_event_o        (key_event_o)
  );

  bit                 key_seen   [KEY_COUNT_DEF];
  bit                 key_level  [KEY_COUNT_DEF];
  logic [STAMP_W-1:0] press_ms   [KEY_COUNT_DEF];
  bit                 frame_hit  [KEY_COUNT_DEF];
  key_event_e         frame_ev   [KEY_COUNT_DEF];
  bit                 gen_level  [KEY_COUNT_DEF];

  key_req_t   req_q[$];
  key_event_e pending_events[$];
  key_event_e want_ev;
  int         mismatch_cnt;
  int         idle_cnt;
  int         stall_left;
  int         stall_mode;
  int         dir_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit predict_event(input key_req_t r, output key_event_e ev);
    key_event_e         raw;
    logic [STAMP_W-1:0] held;
    int                 k;
    ev = EV_UP;
    if (r.eof) begin
      for (int i = 0; i < KEY_COUNT_DEF; i++) frame_hit[i] = 1'b0;
      return 1'b0;
    end
    if (r.key >= KEY_COUNT_DEF) return 1'b0;
    k = int'(r.key);
    if (frame_hit[k]) begin
      raw = frame_ev[k];
    end else begin
      if (!key_seen[k]) begin
        key_seen[k]  = 1'b1;
        key_level[k] = 1'b0;
        press_ms[k]  = r.now;
      end
      if (key_level[k] == r.level) begin
        if (r.level) raw = EV_DOWN;
        else raw = EV_UP;
      end else begin
        if (r.level) raw = EV_PRESS;
        else raw = EV_RELEASE;
      end
      key_level[k] = r.level;
      frame_hit[k] = 1'b1;
      frame_ev[k]  = raw;
    end
    ev = raw;
    if (r.limit != '0) begin
      if (raw == EV_RELEASE) begin
        held = r.now - press_ms[k];
        if (held > STAMP_W'(r.limit)) ev = EV_UP;
      end else if (raw == EV_PRESS) begin
        press_ms[k] = r.now;
      end
    end
    return 1'b1;
  endfunction

  function automatic void add_req(input logic eof, input logic [CODE_W-1:0] key,
                                  input logic level, input logic [LIMIT_W-1:0] limit,
                                  input logic [STAMP_W-1:0] now, input bit typed,
                                  input key_event_e want);
    key_req_t r;
    r.eof   = eof;
    r.key   = key;
    r.level = level;
    r.limit = limit;
    r.now   = now;
    r.typed = typed;
    r.want  = want;
    req_q.push_back(r);
  endfunction

  task automatic build_random();
    logic [STAMP_W-1:0] clk_ms;
    logic [LIMIT_W-1:0] lim;
    logic [CODE_W-1:0]  base;
    logic [CODE_W-1:0]  k;
    logic               eof;
    int                 lim_i;
    int                 queries;
    int                 n;
    queries = 0;
    clk_ms  = $urandom;
    while (queries < N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          eof = ($urandom_range(0, 3) == 0);
          add_req(eof, CODE_W'($urandom), 1'($urandom), LIMIT_W'($urandom), $urandom,
                  1'b0, EV_UP);
          if (!eof) queries++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: lim = '0;
          1: lim = LIMIT_W'($urandom_range(1, 64));
          2: lim = LIMIT_W'($urandom);
          default: lim = '1;
        endcase
        lim_i = int'(lim);
        base  = CODE_W'($urandom);
        if ($urandom_range(0, 15) == 0) clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        n = $urandom_range(1, 12);
        for (int j = 0; j < n; j++) begin
          k = base + CODE_W'($urandom_range(0, 7));
          if ($urandom_range(0, 2) == 0) gen_level[k] = ~gen_level[k];
          if (lim_i == 0) clk_ms += $urandom_range(0, 100);
          else clk_ms += $urandom_range(0, 2 * lim_i + 2);
          add_req(1'b0, k, gen_level[k], lim, clk_ms, 1'b0, EV_UP);
          queries++;
        end
        if ($urandom_range(0, 7) != 0)
          add_req(1'b1, CODE_W'($urandom), 1'($urandom), LIMIT_W'($urandom), $urandom,
                  1'b0, EV_UP);
      end
    end
  endtask

  task automatic send_req(input key_req_t r);
    key_event_e ev;
    push_i             <= 1'b1;
    mode_i             <= r.eof;
    key_code_i         <= r.key;
    key_down_i         <= r.level;
    release_limit_ms_i <= r.limit;
    now_ms_i           <= r.now;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    if (predict_event(r, ev)) begin
      if (r.typed) pending_events.push_back(r.want);
      else pending_events.push_back(ev);
    end
  endtask

  initial begin
    int burst_left;
    int gap;
    rst_ni             <= 1'b0;
    push_i             <= 1'b0;
    pop_i              <= 1'b0;
    mode_i             <= 1'b0;
    key_code_i         <= '0;
    key_down_i         <= 1'b0;
    release_limit_ms_i <= '0;
    now_ms_i           <= '0;
    mismatch_cnt = 0;

    add_req(1'b0, 8'd0,   1'b0, 16'd0,      32'd0,          1'b1, EV_UP);
    add_req(1'b0, 8'd255, 1'b1, 16'hFFFF,   32'hFFFF_FFFF,  1'b1, EV_PRESS);
    add_req(1'b0, 8'd255, 1'b0, 16'hFFFF,   32'd0,          1'b1, EV_PRESS);
    add_req(1'b1, 8'd255, 1'b1, 16'hFFFF,   32'hFFFF_FFFF,  1'b0, EV_UP);
    add_req(1'b0, 8'd255, 1'b0, 16'hFFFF,   32'd5,          1'b1, EV_RELEASE);
    add_req(1'b0, 8'd0,   1'b1, 16'd0,      32'h1234_5678,  1'b0, EV_UP);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd0,   1'b0, 16'd10,     32'h1234_5690,  1'b1, EV_UP);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd0,   1'b1, 16'd100,    32'hFFFF_FFF0,  1'b1, EV_PRESS);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd0,   1'b0, 16'd100,    32'h10,         1'b1, EV_RELEASE);
    add_req(1'b0, 8'd0,   1'b1, 16'd100,    32'h40,         1'b0, EV_UP);
    add_req(1'b0, 8'd0,   1'b1, 16'd100,    32'h60,         1'b0, EV_UP);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd2,   1'b1, 16'd50,     32'd1000,       1'b1, EV_PRESS);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd2,   1'b0, 16'd50,     32'd1050,       1'b1, EV_RELEASE);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd2,   1'b1, 16'd50,     32'd2000,       1'b0, EV_UP);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd2,   1'b1, 16'd50,     32'd2100,       1'b1, EV_DOWN);
    add_req(1'b1, 8'd0,   1'b0, 16'd0,      32'd0,          1'b0, EV_UP);
    add_req(1'b0, 8'd2,   1'b0, 16'd50,     32'd2051,       1'b1, EV_UP);
    add_req(1'b0, 8'd1,   1'b1, 16'd0,      32'hAAAA_5555,  1'b1, EV_PRESS);
    dir_count = req_q.size();
    build_random();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 30);
    for (int i = 0; i < req_q.size(); i++) begin
      send_req(req_q[i]);
      if (i == dir_count - 1 || i == req_q.size() / 2) begin
        // hold off until the block has drained
        push_i <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
      end else if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
    push_i <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_events.size() == 0) begin
        $display("%0t tb: unexpected key_event transfer, expected none, got %0d",
                 $time, key_event_o);
        mismatch_cnt++;
      end else begin
        want_ev = pending_events.pop_front();
        if (key_event_o !== want_ev) begin
          $display("%0t tb: key_event mismatch, expected %0d, got %0d",
                   $time, want_ev, key_event_o);
          mismatch_cnt++;
        end
      end
    end
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: pop_i <= 1'b1;
      1: pop_i <= 1'($urandom_range(0, 1));
      default: pop_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
